[rtl/core/pmc_pkg.sv]
// Shared types, constants and the cursor axis update for the PS/2 mouse packet cursor core.
`timescale 1ns / 1ps
package pmc_pkg;

    localparam int BYTE_W         = 8;
    localparam int LIMIT_W        = 16;
    localparam int OUT_POS_W      = 16;
    localparam int BUTTON_W       = 3;
    localparam int CURSOR_STEP    = 2;
    localparam int POSITION_WIDTH = 16;

    // Status byte bit positions
    localparam int BIT_ALWAYS_ONE = 3;
    localparam int BIT_X_SIGN     = 4;
    localparam int BIT_Y_SIGN     = 5;
    localparam int BIT_X_OVF      = 6;
    localparam int BIT_Y_OVF      = 7;

    localparam logic [LIMIT_W-1:0] WIDTH_LIMIT_RESET  = 16'd1024;
    localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT_RESET = 16'd768;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_LIMIT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_LIMIT = 1'b1;

    // Packet queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POSITION_WIDTH-1:0] t_pos;
    typedef logic [LIMIT_W-1:0]        t_limit;

    localparam t_pos   POS_MAX       = '1;
    localparam t_limit POS_MAX_LIMIT = LIMIT_W'((64'd1 << POSITION_WIDTH) - 64'd1);
    localparam logic [POSITION_WIDTH:0] STEP_EXT = (POSITION_WIDTH + 1)'(CURSOR_STEP);

    // Per-axis motion command
    typedef enum logic [1:0] {
        MV_HOLD = 2'b00,
        MV_INC  = 2'b01,
        MV_DEC  = 2'b10
    } t_move;

    // One classified packet, as handed from the front to the back
    typedef struct packed {
        logic                overflow;
        logic [BUTTON_W-1:0] buttons;
        t_move               move_x;
        t_move               move_y;
    } t_packet;

    // Step one axis, then clamp to 0..min(limit, POS_MAX)
    function automatic t_pos axis_step(input t_pos pos, input t_move move, input t_limit limit);
        logic [POSITION_WIDTH:0] ext;
        logic [POSITION_WIDTH:0] p;
        t_pos                    hi;
        ext = {1'b0, pos};
        hi  = (limit > POS_MAX_LIMIT) ? POS_MAX : limit[POSITION_WIDTH-1:0];
        case (move)
            MV_INC:  p = ext + STEP_EXT;
            MV_DEC:  p = (ext < STEP_EXT) ? '0 : ext - STEP_EXT;
            default: p = ext;
        endcase
        axis_step = (p > {1'b0, hi}) ? hi : p[POSITION_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/pmc_front.sv]
// Front part: assembles mouse bytes into packets and classifies each packet.
`timescale 1ns / 1ps
module pmc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [pmc_pkg::BYTE_W-1:0]   i_mouse_byte,
    input  logic                         i_q_full,
    output logic                         o_in_stall,
    output logic                         o_push,
    output pmc_pkg::t_packet             o_packet
);
    import pmc_pkg::*;

    typedef enum logic [2:0] {
        POS_STATUS  = 3'b001,
        POS_DELTA_X = 3'b010,
        POS_DELTA_Y = 3'b100
    } t_byte_pos;

    t_byte_pos         r_pos, n_pos;
    logic [BYTE_W-1:0] r_status, n_status;
    logic              r_dx_nonzero, n_dx_nonzero;
    logic              accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_pos        = r_pos;
        n_status     = r_status;
        n_dx_nonzero = r_dx_nonzero;
        o_push       = 1'b0;
        if (accept) begin
            unique case (r_pos)
                POS_DELTA_X: begin
                    n_dx_nonzero = (i_mouse_byte != '0);
                    n_pos        = POS_DELTA_Y;
                end
                POS_DELTA_Y: begin
                    o_push = 1'b1;
                    n_pos  = POS_STATUS;
                end
                default: begin
                    // drop a misaligned first byte
                    if (i_mouse_byte[BIT_ALWAYS_ONE]) begin
                        n_status = i_mouse_byte;
                        n_pos    = POS_DELTA_X;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_packet.overflow = r_status[BIT_X_OVF] | r_status[BIT_Y_OVF];
        o_packet.buttons  = r_status[BUTTON_W-1:0];
        if (r_status[BIT_X_SIGN]) begin
            o_packet.move_x = MV_DEC;
        end else if (r_dx_nonzero) begin
            o_packet.move_x = MV_INC;
        end else begin
            o_packet.move_x = MV_HOLD;
        end
        // screen rows grow downward
        if (r_status[BIT_Y_SIGN]) begin
            o_packet.move_y = MV_INC;
        end else if (i_mouse_byte != '0) begin
            o_packet.move_y = MV_DEC;
        end else begin
            o_packet.move_y = MV_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_STATUS;
            r_status     <= '0;
            r_dx_nonzero <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_status     <= n_status;
            r_dx_nonzero <= n_dx_nonzero;
        end
    end

endmodule

[rtl/core/pmc_queue.sv]
// Short packet queue that decouples the front from the back.
`timescale 1ns / 1ps
module pmc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmc_pkg::t_packet i_packet,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output pmc_pkg::t_packet o_packet
);
    import pmc_pkg::*;

    t_packet                r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == CNT_FULL);
    assign o_packet = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/pmc_back.sv]
// Back part: moves and clamps the cursor, latches buttons and holds the result.
`timescale 1ns / 1ps
module pmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pmc_pkg::t_packet              i_packet,
    input  pmc_pkg::t_limit               i_width_limit,
    input  pmc_pkg::t_limit               i_height_limit,
    input  logic                          i_out_stall,
    output logic                          o_pop,
    output logic                          o_out_valid,
    output logic [pmc_pkg::OUT_POS_W-1:0] o_cursor_x,
    output logic [pmc_pkg::OUT_POS_W-1:0] o_cursor_y,
    output logic                          o_left_button,
    output logic                          o_right_button,
    output logic                          o_middle_button,
    output logic                          o_packet_dropped
);
    import pmc_pkg::*;

    t_pos                r_pos_x, n_pos_x;
    t_pos                r_pos_y, n_pos_y;
    logic [BUTTON_W-1:0] r_buttons, n_buttons;
    logic                r_dropped;
    logic                r_out_valid;

    // The held state doubles as the result register: it only changes on a pop,
    // and a pop only happens once the previous result has been taken.
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        if (!i_packet.overflow) begin
            n_pos_x   = axis_step(r_pos_x, i_packet.move_x, i_width_limit);
            n_pos_y   = axis_step(r_pos_y, i_packet.move_y, i_height_limit);
            n_buttons = i_packet.buttons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_buttons   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_buttons <= n_buttons;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dropped <= i_packet.overflow;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cursor_x       = OUT_POS_W'(r_pos_x);
    assign o_cursor_y       = OUT_POS_W'(r_pos_y);
    assign o_left_button    = r_buttons[0];
    assign o_right_button   = r_buttons[1];
    assign o_middle_button  = r_buttons[2];
    assign o_packet_dropped = r_dropped;

endmodule

[rtl/core/ps2_mouse_packet_cursor_core.sv]
// Top level of the PS/2 mouse packet cursor core: front, packet queue, back, limit registers.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------
//  in        | input     | i_in_valid / o_in_stall | i_mouse_byte
//  out       | output    | o_out_valid/ i_out_stall| o_cursor_x, o_cursor_y, buttons,
//            |           |                         | o_packet_dropped
//  cfg       | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One byte per cycle is accepted while o_in_stall is low. A completed packet is pushed into
//  a two-entry queue in the cycle its third byte is taken, and its result is registered in
//  the back when the entry is popped; the cursor update is a single add and clamp per cycle
//  while no stalled result is held. o_in_stall rises only when the queue is full, i.e. when
//  the out channel has been stalled with a result held. Reset (i_rst_n low, synchronous)
//  clears the byte position, cursor, buttons and the queue, and loads the limits 1024 and 768.
//  Configuration is always ready; write limits while no transaction is in flight.
//
module ps2_mouse_packet_cursor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pmc_pkg::BYTE_W-1:0]      i_mouse_byte,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pmc_pkg::OUT_POS_W-1:0]   o_cursor_x,
    output logic [pmc_pkg::OUT_POS_W-1:0]   o_cursor_y,
    output logic                            o_left_button,
    output logic                            o_right_button,
    output logic                            o_middle_button,
    output logic                            o_packet_dropped,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pmc_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import pmc_pkg::*;

    t_limit  r_width_limit;
    t_limit  r_height_limit;
    logic    cfg_write;

    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    logic    q_full;
    t_packet front_packet;
    t_packet back_packet;

    // Configuration: one write per transaction, no back-pressure
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_limit  <= WIDTH_LIMIT_RESET;
            r_height_limit <= HEIGHT_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_WIDTH_LIMIT:  r_width_limit  <= i_cfg_data;
                CFG_HEIGHT_LIMIT: r_height_limit <= i_cfg_data;
                default:          r_width_limit  <= r_width_limit;
            endcase
        end
    end

    // Front: gather bytes, drop misaligned status bytes, classify the packet
    pmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_mouse_byte (i_mouse_byte),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (q_push),
        .o_packet     (front_packet)
    );

    // Queue: absorb a packet while the result channel is stalled
    pmc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_packet (front_packet),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_packet (back_packet)
    );

    // Back: advance the cursor, latch buttons, present the result
    pmc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_packet         (back_packet),
        .i_width_limit    (r_width_limit),
        .i_height_limit   (r_height_limit),
        .i_out_stall      (i_out_stall),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_left_button    (o_left_button),
        .o_right_button   (o_right_button),
        .o_middle_button  (o_middle_button),
        .o_packet_dropped (o_packet_dropped)
    );

endmodule

[rtl/core/pmc_checker.sv]
// Port-level checker for the PS/2 mouse packet cursor core, bound to the top level.
`timescale 1ns / 1ps
module pmc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [pmc_pkg::OUT_POS_W-1:0]   o_cursor_x,
    input logic [pmc_pkg::OUT_POS_W-1:0]   o_cursor_y,
    input logic                            o_left_button,
    input logic                            o_right_button,
    input logic                            o_middle_button,
    input logic                            o_packet_dropped
);
    import pmc_pkg::*;

    // A stalled result holds its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_x)
            && $stable(o_cursor_y) && $stable(o_packet_dropped)
            && $stable({o_left_button, o_right_button, o_middle_button}))
        else $error("result changed while stalled");

    // Input back-pressure only ever comes from a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && $past(o_out_valid))
        else $error("input stalled without a held result");

    // A fresh result follows an accepted byte, registered through the queue and then the result register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a completing byte");

endmodule

bind ps2_mouse_packet_cursor_core pmc_checker u_pmc_checker (.*);

[bench/tb_ps2_mouse_packet_cursor_core.sv]
// Self-checking testbench for the PS/2 mouse packet cursor core: byte stream in, cursor reports out.
`timescale 1ns / 1ps
module tb_ps2_mouse_packet_cursor_core;
    import pmc_pkg::*;

    // One cursor report as seen on the out channel
    typedef struct packed {
        t_pos x;
        t_pos y;
        logic left;
        logic right;
        logic middle;
        logic dropped;
    } t_cursor_report;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int IDLE_PCT        = 10;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;

    // Opening byte stream: misaligned bytes at a packet boundary, quiet packet, all buttons,
    // both sign bits with full deltas, each overflow bit and both, zero X delta, and a
    // byte with the always-one bit clear taken as an X delta in the middle of a packet.
    localparam logic [BYTE_W-1:0] OPENING_BYTES [26] = '{
        8'h00, 8'hF7,
        8'h08, 8'h00, 8'h00,
        8'h0F, 8'h01, 8'h01,
        8'h3F, 8'hFF, 8'hFF,
        8'h48, 8'h05, 8'h05,
        8'h88, 8'h05, 8'h05,
        8'hFF, 8'hFF, 8'hFF,
        8'h09, 8'h00, 8'h80,
        8'h0A, 8'h00, 8'h00
    };

    // Tracks packet framing, cursor position and buttons; holds the reports still owed.
    class cursor_tracker;
        t_limit           width_limit;
        t_limit           height_limit;
        int unsigned      slot;
        logic [BYTE_W-1:0] status_q;
        logic [BYTE_W-1:0] delta_x_q;
        t_pos             pos_x;
        t_pos             pos_y;
        logic [2:0]       buttons;
        t_cursor_report   owed_reports[$];
        int               mismatches;

        function new();
            width_limit  = WIDTH_LIMIT_RESET;
            height_limit = HEIGHT_LIMIT_RESET;
            slot         = 0;
            status_q     = '0;
            delta_x_q    = '0;
            pos_x        = '0;
            pos_y        = '0;
            buttons      = '0;
            mismatches   = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_W-1:0] idx, t_limit value);
            if (idx == CFG_WIDTH_LIMIT) begin
                width_limit = value;
            end else begin
                height_limit = value;
            end
        endfunction

        function t_pos step_axis(t_pos pos, int dir, t_limit limit);
            int p;
            int hi;
            hi = int'(limit);
            if (hi > (1 << POSITION_WIDTH) - 1) begin
                hi = (1 << POSITION_WIDTH) - 1;
            end
            p = int'(pos) + dir * CURSOR_STEP;
            if (p < 0) begin
                p = 0;
            end else if (p > hi) begin
                p = hi;
            end
            return t_pos'(p);
        endfunction

        // Take one accepted byte; return 0 when it is dropped as a misaligned first byte.
        function bit take_byte(logic [BYTE_W-1:0] b);
            t_cursor_report r;
            int dx;
            int dy;
            dx = 0;
            dy = 0;
            if (slot == 1) begin
                delta_x_q = b;
                slot = 2;
                return 1'b1;
            end
            if (slot != 2) begin
                if (!b[BIT_ALWAYS_ONE]) begin
                    return 1'b0;
                end
                status_q = b;
                slot = 1;
                return 1'b1;
            end
            slot = 0;
            r.dropped = status_q[BIT_X_OVF] | status_q[BIT_Y_OVF];
            if (!r.dropped) begin
                buttons = status_q[2:0];
                if (status_q[BIT_X_SIGN]) begin
                    dx = -1;
                end else if (delta_x_q != '0) begin
                    dx = 1;
                end
                // screen rows grow downward, so Y runs opposite to the mouse
                if (status_q[BIT_Y_SIGN]) begin
                    dy = 1;
                end else if (b != '0) begin
                    dy = -1;
                end
                pos_x = step_axis(pos_x, dx, width_limit);
                pos_y = step_axis(pos_y, dy, height_limit);
            end
            r.x      = pos_x;
            r.y      = pos_y;
            r.left   = buttons[0];
            r.right  = buttons[1];
            r.middle = buttons[2];
            owed_reports.push_back(r);
            return 1'b1;
        endfunction

        function void flag(string what, t_cursor_report want, t_cursor_report got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $write("[%0t] %s: expected x=%0d y=%0d l=%b r=%b m=%b drop=%b, ",
                       $realtime, what,
                       want.x, want.y, want.left, want.right, want.middle, want.dropped);
                $display("got x=%0d y=%0d l=%b r=%b m=%b drop=%b",
                         got.x, got.y, got.left, got.right, got.middle, got.dropped);
            end
        endfunction

        function void match_report(t_cursor_report got);
            t_cursor_report want;
            if (owed_reports.size() == 0) begin
                flag("report with none owed", '0, got);
                return;
            end
            want = owed_reports.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.left !== want.left ||
                got.right !== want.right || got.middle !== want.middle ||
                got.dropped !== want.dropped) begin
                flag("report mismatch", want, got);
            end
        endfunction

        function void flush_owed();
            while (owed_reports.size() != 0) begin
                flag("report never seen", owed_reports.pop_front(), '0);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [BYTE_W-1:0]       i_mouse_byte = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [OUT_POS_W-1:0]    o_cursor_x;
    logic [OUT_POS_W-1:0]    o_cursor_y;
    logic                    o_left_button;
    logic                    o_right_button;
    logic                    o_middle_button;
    logic                    o_packet_dropped;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [LIMIT_W-1:0]      i_cfg_data = '0;

    cursor_tracker tracker = new();

    int counted_bytes = 0;
    int cycles = 0;
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;
    bit hold_off_req = 1'b0;
    int hold_left = 0;

    ps2_mouse_packet_cursor_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: end the run if the stream hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: check each report transaction, then pick the stall for the next edge.
    // A requested hold-off starts once the sender is offering bytes and is counted here,
    // independent of the sender, so the two-entry queue fills and the block has to stall
    // its byte input.
    initial begin
        t_cursor_report got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.x       = o_cursor_x;
                got.y       = o_cursor_y;
                got.left    = o_left_button;
                got.right   = o_right_button;
                got.middle  = o_middle_button;
                got.dropped = o_packet_dropped;
                tracker.match_report(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_off_req && i_in_valid) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_out && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one byte, idling first now and then; return once the transaction is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet_in && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mouse_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (tracker.take_byte(b)) begin
            counted_bytes++;
        end
    endtask

    // Emit a packet with random content; sometimes a stray byte or a cut-off packet.
    // With grow set, bias the signs so the cursor drifts to larger x and y.
    task automatic send_packet(input bit grow);
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] dx_byte;
        logic [BYTE_W-1:0] dy_byte;
        int kind;
        kind = $urandom_range(99);
        status = BYTE_W'($urandom);
        if (kind < 8) begin
            status[BIT_ALWAYS_ONE] = 1'b0;
            send_byte(status);
            return;
        end
        status[BIT_ALWAYS_ONE] = 1'b1;
        if ($urandom_range(99) >= 12) begin
            status[BIT_Y_OVF] = 1'b0;
            status[BIT_X_OVF] = 1'b0;
        end
        if (grow) begin
            status[BIT_X_SIGN] = ($urandom_range(99) < 10);
            status[BIT_Y_SIGN] = ($urandom_range(99) >= 10);
        end
        dx_byte = ($urandom_range(99) < 20) ? '0 : BYTE_W'($urandom);
        dy_byte = ($urandom_range(99) < 20) ? '0 : BYTE_W'($urandom);
        send_byte(status);
        send_byte(dx_byte);
        if (kind < 12) begin
            return;
        end
        send_byte(dy_byte);
    endtask

    // Write one limit register; the caller lowers valid after its last write
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input t_limit value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_limit(idx, value);
    endtask

    // Wait until every owed report is in, then let the pipe settle
    task automatic drain_reports();
        while (tracker.owed_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_limit wl, input t_limit hl, input int n, input bit grow);
        int start;
        drain_reports();
        cfg_write(CFG_WIDTH_LIMIT, wl);
        cfg_write(CFG_HEIGHT_LIMIT, hl);
        i_cfg_valid <= 1'b0;
        start = counted_bytes;
        while (counted_bytes - start < n) send_packet(grow);
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed stream at the reset limits
        foreach (OPENING_BYTES[k]) send_byte(OPENING_BYTES[k]);
        i_in_valid <= 1'b0;

        // Widest limits; drift outward and hold off the receiver for a long stretch
        hold_off_req = 1'b1;
        run_phase(16'hFFFF, 16'hFFFF, 140, 1'b1);
        // Tiny limits pull the cursor in; no idling on either side
        quiet_in  = 1'b1;
        quiet_out = 1'b1;
        run_phase(16'd7, 16'd5, 120, 1'b0);
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        // Zero limits pin the cursor at the origin
        run_phase(16'd0, 16'd0, 80, 1'b0);
        // Mixed limits with outward drift, then a narrow column
        run_phase(16'd40, 16'd3333, 120, 1'b1);
        run_phase(16'd1, 16'hFFFF, 140, 1'b0);

        drain_reports();
        tracker.flush_owed();
        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
